FILE: rtl/cle_pkg.sv
`default_nettype none
package cle_pkg;

  localparam int CAPACITY = 64;
  localparam int CNT_W    = $clog2(CAPACITY + 1);

  localparam logic [7:0] KEY_DELETE = 8'd45;
  localparam logic [7:0] KEY_LEFT   = 8'd60;
  localparam logic [7:0] KEY_RIGHT  = 8'd62;

  typedef enum logic [1:0] {
    CELL_HOLD = 2'd0,
    CELL_INS  = 2'd1,
    CELL_DEL  = 2'd2,
    CELL_SHL  = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t   op;
    logic [7:0] key;
  } cell_ctl_t;

endpackage
`default_nettype wire

FILE: rtl/cle_cell.sv
`default_nettype none
module cle_cell (
  input  wire               clk,
  input  wire cle_pkg::cell_ctl_t ctl,
  input  wire               ge_left,
  input  wire               ge_self,
  input  wire               ge_right,
  input  wire  [7:0]        left_data,
  input  wire  [7:0]        right_data,
  output logic [7:0]        data_o
);
  import cle_pkg::*;

  logic [7:0] data_r;
  logic [7:0] data_nxt;

  // ge_* say whether the neighbor / this cell sits at or past the cursor
  always_comb begin
    data_nxt = data_r;
    unique case (ctl.op)
      CELL_HOLD: data_nxt = data_r;
      CELL_INS: begin
        if (ge_left) begin
          data_nxt = left_data;
        end else if (ge_self) begin
          data_nxt = ctl.key;
        end
      end
      CELL_DEL: begin
        if (ge_right) begin
          data_nxt = right_data;
        end
      end
      CELL_SHL: data_nxt = right_data;
      default:  data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule
`default_nettype wire

FILE: rtl/cursor_line_editor.sv
`default_nettype none
// Line editor over a row of character cells, one cell per line position, with the
// cursor and line length held in counters. An edit keystroke is taken in the cycle it
// arrives, and the cells shift toward or away from the cursor in one step. A
// keystroke with in_tlast set is applied and then the line is shifted out of cell 0,
// one character per cycle while out_tready is high, and no keystroke is taken until
// the last character (a single zero beat for an empty line) has left the cells. The
// drain rate is set by the single read port at cell 0.
module cursor_line_editor (
  input  wire        clk,
  input  wire        rst_n,
  input  wire        in_tvalid,
  output logic       in_tready,
  input  wire  [7:0] in_tdata,   // key[7:0]
  input  wire        in_tlast,   // end_of_line
  output logic       out_tvalid,
  input  wire        out_tready,
  output logic [7:0] out_tdata,  // text_char[7:0]
  output logic       out_tlast,  // is_last
  output logic [1:0] out_tuser   // overflowed, line_empty
);
  import cle_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_DRAIN = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  cur_r, cur_nxt;
  logic [CNT_W-1:0]  len_r, len_nxt;
  logic              ovf_r, ovf_nxt;
  logic              ov_r, ov_nxt;
  logic [7:0]        od_r, od_nxt;
  logic              ol_r, ol_nxt;
  logic [1:0]        ou_r, ou_nxt;
  cell_ctl_t         ctl;
  logic              accept, slot_free;
  logic [CAPACITY-1:0] ge;
  logic [7:0]        cell_q [CAPACITY];

  assign accept    = in_tvalid && in_tready;
  assign slot_free = !ov_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    ovf_nxt   = ovf_r;
    ov_nxt    = ov_r;
    od_nxt    = od_r;
    ol_nxt    = ol_r;
    ou_nxt    = ou_r;
    ctl.op    = CELL_HOLD;
    ctl.key   = in_tdata;

    if (ov_r && out_tready) begin
      ov_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          priority if (in_tdata == KEY_DELETE) begin
            if (cur_r != '0) begin
              ctl.op  = CELL_DEL;
              cur_nxt = cur_r - 1'b1;
              len_nxt = len_r - 1'b1;
            end
          end else if (in_tdata == KEY_LEFT) begin
            if (cur_r != '0) begin
              cur_nxt = cur_r - 1'b1;
            end
          end else if (in_tdata == KEY_RIGHT) begin
            if (len_r != cur_r) begin
              cur_nxt = cur_r + 1'b1;
            end
          end else begin
            if (len_r == CNT_W'(CAPACITY)) begin
              ovf_nxt = 1'b1;
            end else begin
              ctl.op  = CELL_INS;
              cur_nxt = cur_r + 1'b1;
              len_nxt = len_r + 1'b1;
            end
          end
          if (in_tlast) begin
            state_nxt = ST_DRAIN;
            cur_nxt   = '0;
          end
        end
      end
      ST_DRAIN: begin
        if (slot_free) begin
          ov_nxt = 1'b1;
          if (len_r == '0) begin
            od_nxt    = 8'd0;
            ol_nxt    = 1'b1;
            ou_nxt    = {ovf_r, 1'b1};
            ovf_nxt   = 1'b0;
            state_nxt = ST_IDLE;
          end else begin
            ctl.op  = CELL_SHL;
            od_nxt  = cell_q[0];
            ol_nxt  = (len_r == CNT_W'(1));
            ou_nxt  = {ovf_r, 1'b0};
            len_nxt = len_r - 1'b1;
            if (len_r == CNT_W'(1)) begin
              ovf_nxt   = 1'b0;
              state_nxt = ST_IDLE;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cur_r   <= '0;
      len_r   <= '0;
      ovf_r   <= 1'b0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cur_r   <= cur_nxt;
      len_r   <= len_nxt;
      ovf_r   <= ovf_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ol_r <= ol_nxt;
    ou_r <= ou_nxt;
  end

  // thermometer of the cursor: position i is at or right of the cursor
  genvar gi;
  generate
    for (gi = 0; gi < CAPACITY; gi++) begin : g_cell
      assign ge[gi] = (cur_r <= CNT_W'(gi));
      cle_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .ge_left   ((gi == 0) ? 1'b0 : ge[(gi == 0) ? 0 : gi - 1]),
        .ge_self   (ge[gi]),
        .ge_right  ((gi == CAPACITY - 1) ? 1'b1 : ge[(gi == CAPACITY - 1) ? gi : gi + 1]),
        .left_data ((gi == 0) ? 8'd0 : cell_q[(gi == 0) ? 0 : gi - 1]),
        .right_data((gi == CAPACITY - 1) ? 8'd0
                                          : cell_q[(gi == CAPACITY - 1) ? gi : gi + 1]),
        .data_o    (cell_q[gi])
      );
    end
  endgenerate

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;
  assign out_tlast  = ol_r;
  assign out_tuser  = ou_r;

endmodule
`default_nettype wire

FILE: rtl/cle_checker.sv
`default_nettype none
module cle_checker (
  input wire       clk,
  input wire       rst_n,
  input wire       in_tvalid,
  input wire       in_tready,
  input wire       in_tlast,
  input wire       out_tvalid,
  input wire       out_tready,
  input wire [7:0] out_tdata,
  input wire       out_tlast,
  input wire [1:0] out_tuser
);

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tlast) && $stable(out_tuser))
    else $error("result beat changed while stalled");

  // empty-line beat is a lone zero beat
  a_empty_beat: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[0] |-> out_tlast && (out_tdata == 8'd0))
    else $error("empty-line beat malformed");

  // end of line stops keystrokes while the line goes out
  a_eol_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("keystroke taken right after end of line");

  // a non-final beat on the output means the line is still draining
  a_mid_line: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tlast |-> !in_tready)
    else $error("keystroke taken in the middle of a line");

endmodule

bind cursor_line_editor cle_checker u_cle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_tvalid (in_tvalid),
  .in_tready (in_tready),
  .in_tlast  (in_tlast),
  .out_tvalid(out_tvalid),
  .out_tready(out_tready),
  .out_tdata (out_tdata),
  .out_tlast (out_tlast),
  .out_tuser (out_tuser)
);
`default_nettype wire

FILE: dv/tb_top.sv
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import cle_pkg::*;

  localparam int HOLD_CYCLES = 300;

  typedef struct {
    logic [7:0] key;
    logic       eol;
  } keystroke_t;

  typedef struct {
    logic [7:0] text_char;
    logic       is_last;
    logic       line_empty;
    logic       overflowed;
  } line_beat_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // key[7:0]
  logic       in_tlast = 1'b0;    // end_of_line
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // text_char[7:0]
  logic       out_tlast;          // is_last
  logic [1:0] out_tuser;          // overflowed, line_empty

  cursor_line_editor DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // pending keystrokes and the text beats they are expected to produce
  keystroke_t keystrokes[$];
  line_beat_t expected_text[$];

  // editor image: two stacks meeting at the cursor
  logic [7:0] left_chars [CAPACITY];
  logic [7:0] right_chars[CAPACITY];
  int         n_left = 0;
  int         n_right = 0;
  logic       dropped_char = 1'b0;

  int errors = 0;
  int keys_taken = 0;
  int lines_seen = 0;
  int empty_lines = 0;
  int ovf_lines = 0;
  int beats_checked = 0;

  task automatic edit_and_emit(input logic [7:0] key, input logic eol);
    line_beat_t b;
    int total;
    int n;
    if (key == KEY_DELETE) begin
      if (n_left > 0) n_left--;
    end else if (key == KEY_LEFT) begin
      if (n_left > 0 && n_right < CAPACITY) begin
        n_left--;
        right_chars[n_right] = left_chars[n_left];
        n_right++;
      end
    end else if (key == KEY_RIGHT) begin
      if (n_right > 0 && n_left < CAPACITY) begin
        n_right--;
        left_chars[n_left] = right_chars[n_right];
        n_left++;
      end
    end else if (n_left + n_right >= CAPACITY) begin
      dropped_char = 1'b1;
    end else begin
      left_chars[n_left] = key;
      n_left++;
    end
    if (!eol) return;

    lines_seen++;
    if (dropped_char) ovf_lines++;
    total = n_left + n_right;
    b.overflowed = dropped_char;
    if (total == 0) begin
      empty_lines++;
      b.text_char  = 8'h00;
      b.is_last    = 1'b1;
      b.line_empty = 1'b1;
      expected_text = {expected_text, b};
    end else begin
      b.line_empty = 1'b0;
      for (n = 0; n < total; n++) begin
        b.text_char = (n < n_left) ? left_chars[n] : right_chars[total - 1 - n];
        b.is_last   = (n == total - 1);
        expected_text = {expected_text, b};
      end
    end
    n_left = 0;
    n_right = 0;
    dropped_char = 1'b0;
  endtask

  function automatic logic [7:0] typed_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == KEY_DELETE || c == KEY_LEFT || c == KEY_RIGHT) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  function automatic logic [7:0] rand_key();
    unique case ($urandom_range(0, 9))
      0: return KEY_DELETE;
      1: return KEY_LEFT;
      2: return KEY_RIGHT;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  task automatic push_key(input logic [7:0] key, input logic eol);
    keystroke_t ks;
    ks.key = key;
    ks.eol = eol;
    keystrokes = {keystrokes, ks};
  endtask

  // sender: bursts of random length separated by random gaps
  keystroke_t next_key;
  int burst_left = 0;
  int gap_left = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata  <= 8'h00;
      in_tlast  <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        edit_and_emit(in_tdata, in_tlast);
        keys_taken++;
      end
      if (!in_tvalid || in_tready) begin
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 16);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
        end
        if (gap_left > 0 || keystrokes.size() == 0) begin
          if (gap_left > 0) gap_left--;
          in_tvalid <= 1'b0;
        end else begin
          next_key = keystrokes[0];
          keystrokes.delete(0);
          in_tvalid <= 1'b1;
          in_tdata  <= next_key.key;
          in_tlast  <= next_key.eol;
          burst_left--;
        end
      end
    end
  end

  // receiver: stall pattern rotates through four modes, plus one long hold-off
  int rx_cycle = 0;
  int rx_beats = 0;
  int hold_left = 0;
  logic hold_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      rx_cycle++;
      if (out_tvalid && out_tready) rx_beats++;
      if (hold_left > 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else if (!hold_done && rx_beats >= 20) begin
        hold_done = 1'b1;
        hold_left = HOLD_CYCLES - 1;
        out_tready <= 1'b0;
      end else begin
        unique case ((rx_cycle / 64) % 4)
          0: out_tready <= 1'b1;
          1: out_tready <= 1'($urandom_range(0, 1));
          2: out_tready <= (rx_cycle % 4 == 0);
          default: out_tready <= ($urandom_range(0, 4) != 0);
        endcase
      end
    end
  end

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, want, got);
      errors++;
    end
  endtask

  line_beat_t want_beat;

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      beats_checked++;
      if (expected_text.size() == 0) begin
        $display("%0t: text beat with nothing expected, expected none actual %02h/%b/%b",
                 $time, out_tdata, out_tlast, out_tuser);
        errors++;
      end else begin
        want_beat = expected_text[0];
        expected_text.delete(0);
        check_field("text_char", int'(want_beat.text_char), int'(out_tdata));
        check_field("is_last", int'(want_beat.is_last), int'(out_tlast));
        check_field("line_empty", int'(want_beat.line_empty), int'(out_tuser[0]));
        check_field("overflowed", int'(want_beat.overflowed), int'(out_tuser[1]));
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb_top: errors");
    $finish;
  end

  initial begin
    int i;
    int len;
    int random_items;

    // empty lines, each with an edit that is ignored at the edge
    push_key(KEY_DELETE, 1'b1);
    push_key(KEY_LEFT, 1'b1);
    push_key(KEY_RIGHT, 1'b1);
    // byte extremes, cursor walking past both edges, insert mid-line
    push_key(8'h00, 1'b0);
    push_key(8'hff, 1'b0);
    push_key(8'h61, 1'b0);
    push_key(KEY_LEFT, 1'b0);
    push_key(KEY_LEFT, 1'b0);
    push_key(KEY_LEFT, 1'b0);
    push_key(KEY_LEFT, 1'b0);
    push_key(KEY_RIGHT, 1'b0);
    push_key(8'h62, 1'b0);
    push_key(KEY_RIGHT, 1'b0);
    push_key(KEY_RIGHT, 1'b0);
    push_key(KEY_RIGHT, 1'b0);
    push_key(KEY_DELETE, 1'b0);
    push_key(8'h63, 1'b1);
    // line emptied by deletes
    push_key(8'h78, 1'b0);
    push_key(KEY_DELETE, 1'b1);

    // full buffer: drops set the flag, which holds to the end of the line
    for (i = 0; i < CAPACITY; i++) push_key(typed_char(), 1'b0);
    for (i = 0; i < 5; i++) push_key(KEY_LEFT, 1'b0);
    push_key(typed_char(), 1'b0);
    push_key(typed_char(), 1'b0);
    push_key(KEY_DELETE, 1'b0);
    push_key(typed_char(), 1'b1);

    random_items = 0;
    while (random_items < 70) begin
      len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 30) : $urandom_range(1, 8);
      for (i = 0; i < len - 1; i++) push_key(rand_key(), 1'b0);
      push_key(rand_key(), 1'b1);
      random_items += len;
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (keystrokes.size() != 0 || in_tvalid) @(posedge clk);
    while (expected_text.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("run covered %0d keystrokes in %0d lines (%0d empty, %0d with dropped chars)",
             keys_taken, lines_seen, empty_lines, ovf_lines);
    $display("%0d text beats checked, one receiver hold-off of %0d cycles",
             beats_checked, HOLD_CYCLES);
    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule
